FILE: rtl/core/bptc_pkg.sv
package bptc_pkg;

   localparam int TEMP_FRAC_BITS_DEFAULT  = 16;
   localparam int PRESS_FRAC_BITS_DEFAULT = 6;
   localparam int LT_FRAC                 = 28;

   localparam int RAW_W      = 24;
   localparam int OUT_W      = 24;
   localparam int LT_W       = 40;
   localparam int CALIB_LO_W = 64;
   localparam int CALIB_MD_W = 64;
   localparam int CALIB_HI_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_MID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_EN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_EN   = 3'd4;

   localparam int MUL_A_W    = 64;
   localparam int MUL_B_W    = 48;
   localparam int DIGIT_W    = 16;
   localparam int NUM_DIGITS = 3;
   localparam int P_OFFSET   = 16384;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] FIRST_TEMP_STEP  = 5'd0;
   localparam logic [STEP_W-1:0] LAST_TEMP_STEP   = 5'd2;
   localparam logic [STEP_W-1:0] FIRST_PRESS_STEP = 5'd3;
   localparam logic [STEP_W-1:0] LAST_PRESS_STEP  = 5'd19;

   typedef enum logic [4:0] {
      A_D, A_X, A_T, A_T2, A_T3, A_S, A_Q, A_R, A_RAWP,
      A_P1M, A_P2M, A_P3, A_P5, A_P6, A_P7, A_P9, A_P10
   } a_sel_type;

   typedef enum logic [3:0] {
      B_ONE, B_D, B_T, B_T2, B_RAWP, B_R, B_CT2, B_CT3, B_P4, B_P8, B_P11
   } b_sel_type;

   typedef enum logic [3:0] {
      D_ACC_LOAD, D_ACC_ADD, D_S_LOAD, D_S_ADD, D_Q_LOAD, D_Q_ADD,
      D_X, D_T2, D_T3, D_R
   } dest_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      logic [4:0] rsh;
      logic [4:0] lsh;
      dest_type   dest;
   } op_type;

   typedef struct packed {
      logic              accept;
      logic              mul_en;
      logic [1:0]        digit;
      logic              wb;
      logic [STEP_W-1:0] step;
      logic              lt_write;
      logic              press_write;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic temp_en;
      logic press_en;
   } status_type;

   function automatic op_type step_op(input logic [STEP_W-1:0] step);
      op_type op;
      unique case (step)
         5'd0:    op = '{A_D,    B_CT2,  5'd0,  5'd18, D_ACC_LOAD};
         5'd1:    op = '{A_D,    B_D,    5'd0,  5'd0,  D_X};
         5'd2:    op = '{A_X,    B_CT3,  5'd0,  5'd0,  D_ACC_ADD};
         5'd3:    op = '{A_T,    B_T,    5'd16, 5'd0,  D_T2};
         5'd4:    op = '{A_T2,   B_T,    5'd16, 5'd0,  D_T3};
         5'd5:    op = '{A_P5,   B_ONE,  5'd0,  5'd19, D_ACC_LOAD};
         5'd6:    op = '{A_P6,   B_T,    5'd6,  5'd0,  D_ACC_ADD};
         5'd7:    op = '{A_P7,   B_T2,   5'd8,  5'd0,  D_ACC_ADD};
         5'd8:    op = '{A_T3,   B_P8,   5'd15, 5'd0,  D_ACC_ADD};
         5'd9:    op = '{A_P1M,  B_ONE,  5'd0,  5'd20, D_S_LOAD};
         5'd10:   op = '{A_P2M,  B_T,    5'd5,  5'd0,  D_S_ADD};
         5'd11:   op = '{A_P3,   B_T2,   5'd8,  5'd0,  D_S_ADD};
         5'd12:   op = '{A_T3,   B_P4,   5'd13, 5'd0,  D_S_ADD};
         5'd13:   op = '{A_S,    B_RAWP, 5'd24, 5'd0,  D_ACC_ADD};
         5'd14:   op = '{A_RAWP, B_RAWP, 5'd18, 5'd0,  D_R};
         5'd15:   op = '{A_P9,   B_ONE,  5'd0,  5'd16, D_Q_LOAD};
         5'd16:   op = '{A_P10,  B_T,    5'd0,  5'd0,  D_Q_ADD};
         5'd17:   op = '{A_Q,    B_R,    5'd30, 5'd0,  D_ACC_ADD};
         5'd18:   op = '{A_R,    B_RAWP, 5'd0,  5'd0,  D_X};
         5'd19:   op = '{A_X,    B_P11,  5'd31, 5'd0,  D_ACC_ADD};
         default: op = '{A_D,    B_ONE,  5'd0,  5'd0,  D_X};
      endcase
      return op;
   endfunction

endpackage

FILE: rtl/core/bptc_ctrl.sv
module bptc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  bptc_pkg::status_type  status,
   output bptc_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_WB   = 3'd2;
   localparam logic [2:0] S_TFIN = 3'd3;
   localparam logic [2:0] S_PFIN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [bptc_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0]                  digit_ff, digit_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      digit_in   = digit_ff;
      cmd        = '0;
      cmd.step   = step_ff;
      cmd.digit  = digit_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            digit_in = 2'd0;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.temp_en) begin
                  state_in = S_MUL;
                  step_in  = bptc_pkg::FIRST_TEMP_STEP;
               end else if (status.press_en) begin
                  state_in = S_MUL;
                  step_in  = bptc_pkg::FIRST_PRESS_STEP;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            if (digit_ff == 2'(bptc_pkg::NUM_DIGITS - 1)) begin
               digit_in = 2'd0;
               state_in = S_WB;
            end else begin
               digit_in = digit_ff + 2'd1;
            end
         end
         S_WB: begin
            cmd.wb = 1'b1;
            if (step_ff == bptc_pkg::LAST_TEMP_STEP) begin
               state_in = S_TFIN;
            end else if (step_ff == bptc_pkg::LAST_PRESS_STEP) begin
               state_in = S_PFIN;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = S_MUL;
            end
         end
         S_TFIN: begin
            cmd.lt_write = 1'b1;
            if (status.press_en) begin
               step_in  = bptc_pkg::FIRST_PRESS_STEP;
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PFIN: begin
            cmd.press_write = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         digit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/bptc_dpath.sv
module bptc_dpath #(
   parameter int TEMP_FRAC_BITS  = bptc_pkg::TEMP_FRAC_BITS_DEFAULT,
   parameter int PRESS_FRAC_BITS = bptc_pkg::PRESS_FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic [bptc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  bptc_pkg::cmd_type                 cmd,
   output bptc_pkg::status_type              status,
   output logic [bptc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [bptc_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int TSH = bptc_pkg::LT_FRAC - TEMP_FRAC_BITS;
   localparam int PSH = 16 - PRESS_FRAC_BITS;
   localparam logic signed [40:0] T_RND = 41'(longint'(1) << (TSH - 1));
   localparam logic signed [63:0] P_RND = 64'(longint'(1) << (PSH - 1));
   localparam longint T_CLAMP_MAX = 16777215;
   localparam longint T_CLAMP_MIN = -16777216;
   localparam longint OUT_S_MAX   = 8388607;
   localparam longint OUT_S_MIN   = -8388608;
   localparam longint OUT_U_MAX   = 16777215;

   logic [bptc_pkg::CALIB_LO_W-1:0] calib_low_ff;
   logic [bptc_pkg::CALIB_MD_W-1:0] calib_mid_ff;
   logic [bptc_pkg::CALIB_HI_W-1:0] calib_high_ff;
   logic                            temp_en_ff, press_en_ff;
   logic [bptc_pkg::RAW_W-1:0]      raw_p_ff, raw_t_ff;
   logic                            upd_t_ff, upd_p_ff;
   logic signed [bptc_pkg::LT_W-1:0] lt_ff, lt_in;
   logic [bptc_pkg::OUT_W-1:0]      held_p_ff, held_p_in;
   logic signed [63:0]              prod_ff, prod_in;
   logic signed [63:0]              acc_ff, acc_in;
   logic signed [37:0]              s_ff, s_in;
   logic signed [33:0]              q_ff, q_in;
   logic signed [55:0]              x_ff, x_in;
   logic signed [33:0]              t2_ff, t2_in;
   logic signed [41:0]              t3_ff, t3_in;
   logic signed [30:0]              r_ff, r_in;
   logic [bptc_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [bptc_pkg::RSP_USER_W-1:0] rsp_tuser_ff;

   logic [167:0]        calib;
   logic [15:0]         c_t1, c_t2, p5, p6;
   logic signed [7:0]   c_t3, p3, p4, p7, p8, p10, p11;
   logic signed [15:0]  p1, p2, p9;
   logic signed [17:0]  p1m, p2m;
   logic signed [25:0]  d;
   logic signed [39:0]  lt_shr;
   logic signed [24:0]  t;
   bptc_pkg::op_type    op;
   logic signed [bptc_pkg::MUL_A_W-1:0] a_val;
   logic signed [bptc_pkg::MUL_B_W-1:0] b_val;
   logic signed [bptc_pkg::DIGIT_W:0]   dig;
   logic signed [80:0]  full;
   logic [63:0]         part_sh;
   logic signed [63:0]  term;
   logic signed [63:0]  p_sum, p_out;
   logic signed [40:0]  t_sum, t_out;
   logic signed [23:0]  tq;

   assign calib = {calib_high_ff, calib_mid_ff, calib_low_ff};
   assign c_t1  = calib[15:0];
   assign c_t2  = calib[31:16];
   assign c_t3  = calib[39:32];
   assign p1    = calib[55:40];
   assign p2    = calib[71:56];
   assign p3    = calib[79:72];
   assign p4    = calib[87:80];
   assign p5    = calib[103:88];
   assign p6    = calib[119:104];
   assign p7    = calib[127:120];
   assign p8    = calib[135:128];
   assign p9    = calib[151:136];
   assign p10   = calib[159:152];
   assign p11   = calib[167:160];
   assign p1m   = 18'(p1) - 18'(bptc_pkg::P_OFFSET);
   assign p2m   = 18'(p2) - 18'(bptc_pkg::P_OFFSET);

   assign d      = $signed(26'(raw_t_ff)) - $signed(26'({c_t1, 8'h00}));
   assign lt_shr = lt_ff >>> (bptc_pkg::LT_FRAC - 16);

   always_comb begin
      if (lt_shr > T_CLAMP_MAX) begin
         t = 25'(T_CLAMP_MAX);
      end else if (lt_shr < T_CLAMP_MIN) begin
         t = 25'(T_CLAMP_MIN);
      end else begin
         t = lt_shr[24:0];
      end
   end

   assign op = bptc_pkg::step_op(cmd.step);

   always_comb begin
      unique case (op.a_sel)
         bptc_pkg::A_D:    a_val = 64'(d);
         bptc_pkg::A_X:    a_val = 64'(x_ff);
         bptc_pkg::A_T:    a_val = 64'(t);
         bptc_pkg::A_T2:   a_val = 64'(t2_ff);
         bptc_pkg::A_T3:   a_val = 64'(t3_ff);
         bptc_pkg::A_S:    a_val = 64'(s_ff);
         bptc_pkg::A_Q:    a_val = 64'(q_ff);
         bptc_pkg::A_R:    a_val = 64'(r_ff);
         bptc_pkg::A_RAWP: a_val = 64'(raw_p_ff);
         bptc_pkg::A_P1M:  a_val = 64'(p1m);
         bptc_pkg::A_P2M:  a_val = 64'(p2m);
         bptc_pkg::A_P3:   a_val = 64'(p3);
         bptc_pkg::A_P5:   a_val = 64'(p5);
         bptc_pkg::A_P6:   a_val = 64'(p6);
         bptc_pkg::A_P7:   a_val = 64'(p7);
         bptc_pkg::A_P9:   a_val = 64'(p9);
         bptc_pkg::A_P10:  a_val = 64'(p10);
         default:          a_val = '0;
      endcase
   end

   always_comb begin
      unique case (op.b_sel)
         bptc_pkg::B_ONE:  b_val = 48'sd1;
         bptc_pkg::B_D:    b_val = 48'(d);
         bptc_pkg::B_T:    b_val = 48'(t);
         bptc_pkg::B_T2:   b_val = 48'(t2_ff);
         bptc_pkg::B_RAWP: b_val = 48'(raw_p_ff);
         bptc_pkg::B_R:    b_val = 48'(r_ff);
         bptc_pkg::B_CT2:  b_val = 48'(c_t2);
         bptc_pkg::B_CT3:  b_val = 48'(c_t3);
         bptc_pkg::B_P4:   b_val = 48'(p4);
         bptc_pkg::B_P8:   b_val = 48'(p8);
         bptc_pkg::B_P11:  b_val = 48'(p11);
         default:          b_val = '0;
      endcase
   end

   always_comb begin
      case (cmd.digit)
         2'd0:    dig = $signed({1'b0, b_val[15:0]});
         2'd1:    dig = $signed({1'b0, b_val[31:16]});
         default: dig = 17'($signed(b_val[47:32]));
      endcase
   end

   assign full = a_val * dig;

   always_comb begin
      case (cmd.digit)
         2'd0:    part_sh = full[63:0];
         2'd1:    part_sh = {full[47:0], 16'h0000};
         default: part_sh = {full[31:0], 32'h0000_0000};
      endcase
   end

   assign prod_in = (cmd.digit == 2'd0) ? $signed(part_sh) : prod_ff + $signed(part_sh);
   assign term    = (prod_ff >>> op.rsh) <<< op.lsh;

   always_comb begin
      acc_in = acc_ff;
      s_in   = s_ff;
      q_in   = q_ff;
      x_in   = x_ff;
      t2_in  = t2_ff;
      t3_in  = t3_ff;
      r_in   = r_ff;
      unique case (op.dest)
         bptc_pkg::D_ACC_LOAD: acc_in = term;
         bptc_pkg::D_ACC_ADD:  acc_in = acc_ff + term;
         bptc_pkg::D_S_LOAD:   s_in   = 38'(term);
         bptc_pkg::D_S_ADD:    s_in   = s_ff + 38'(term);
         bptc_pkg::D_Q_LOAD:   q_in   = 34'(term);
         bptc_pkg::D_Q_ADD:    q_in   = q_ff + 34'(term);
         bptc_pkg::D_X:        x_in   = 56'(term);
         bptc_pkg::D_T2:       t2_in  = 34'(term);
         bptc_pkg::D_T3:       t3_in  = 42'(term);
         bptc_pkg::D_R:        r_in   = 31'(term);
         default:              acc_in = acc_ff;
      endcase
   end

   assign lt_in = 40'((acc_ff + 64'sd524288) >>> 20);
   assign p_sum = acc_ff + P_RND;
   assign p_out = p_sum >>> PSH;

   always_comb begin
      if (p_out < 0) begin
         held_p_in = '0;
      end else if (p_out > OUT_U_MAX) begin
         held_p_in = 24'(OUT_U_MAX);
      end else begin
         held_p_in = p_out[23:0];
      end
   end

   assign t_sum = 41'(lt_ff) + T_RND;
   assign t_out = t_sum >>> TSH;

   always_comb begin
      if (t_out > OUT_S_MAX) begin
         tq = 24'(OUT_S_MAX);
      end else if (t_out < OUT_S_MIN) begin
         tq = 24'(OUT_S_MIN);
      end else begin
         tq = t_out[23:0];
      end
   end

   assign rsp_tdata_in = {held_p_ff, tq};

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_low_ff  <= '0;
         calib_mid_ff  <= '0;
         calib_high_ff <= '0;
         temp_en_ff    <= 1'b0;
         press_en_ff   <= 1'b0;
         lt_ff         <= '0;
         held_p_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               bptc_pkg::CSR_CALIB_LOW:  calib_low_ff  <= csr_wr_data;
               bptc_pkg::CSR_CALIB_MID:  calib_mid_ff  <= csr_wr_data;
               bptc_pkg::CSR_CALIB_HIGH: calib_high_ff <= csr_wr_data[bptc_pkg::CALIB_HI_W-1:0];
               bptc_pkg::CSR_TEMP_EN:    temp_en_ff    <= csr_wr_data[0];
               bptc_pkg::CSR_PRESS_EN:   press_en_ff   <= csr_wr_data[0];
               default:                  temp_en_ff    <= temp_en_ff;
            endcase
         end
         if (cmd.lt_write) begin
            lt_ff <= lt_in;
         end
         if (cmd.press_write) begin
            held_p_ff <= held_p_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_p_ff <= req_tdata[23:0];
         raw_t_ff <= req_tdata[47:24];
         upd_t_ff <= temp_en_ff;
         upd_p_ff <= press_en_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.wb) begin
         acc_ff <= acc_in;
         s_ff   <= s_in;
         q_ff   <= q_in;
         x_ff   <= x_in;
         t2_ff  <= t2_in;
         t3_ff  <= t3_in;
         r_ff   <= r_in;
      end
      if (cmd.out_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= {upd_p_ff, upd_t_ff};
      end
   end

   assign status.temp_en  = temp_en_ff;
   assign status.press_en = press_en_ff;
   assign rsp_tdata       = rsp_tdata_ff;
   assign rsp_tuser       = rsp_tuser_ff;

endmodule

FILE: rtl/core/baro_pressure_temp_compensation_top.sv
// Barometer compensation: each transfer on the req side carries one raw pressure and one raw
// temperature reading, and gives exactly one transfer on the rsp side with the temperature in
// 2^-TEMP_FRAC_BITS degC and the pressure in 2^-PRESS_FRAC_BITS Pa, both saturating. Disabled
// quantities repeat their last value with their update flag clear. All products go through one
// shared 64 by 17 bit signed multiplier, which builds each product from the 16-bit digits of its
// second operand and then writes it back. The block takes one item at a time. Configuration
// must be written only while no item is in work.
module baro_pressure_temp_compensation_top #(
   parameter int TEMP_FRAC_BITS  = bptc_pkg::TEMP_FRAC_BITS_DEFAULT,
   parameter int PRESS_FRAC_BITS = bptc_pkg::PRESS_FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // raw_pressure [23:0], raw_temperature [47:24]
   input  logic [bptc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // temperature_q16 [23:0], pressure_q6 [47:24]
   output logic [bptc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // temp_updated [0], press_updated [1]
   output logic [bptc_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   bptc_pkg::cmd_type    cmd;
   bptc_pkg::status_type status;

   bptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bptc_dpath #(
      .TEMP_FRAC_BITS  (TEMP_FRAC_BITS),
      .PRESS_FRAC_BITS (PRESS_FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

FILE: rtl/core/bptc_checker.sv
module bptc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bptc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bptc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while the previous item was still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result transfer changed");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without an item in work");

endmodule

bind baro_pressure_temp_compensation_top bptc_checker u_bptc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
